/* rtl/core/fnr_pkg.sv */
// Shared types, register codes and fixed-point helpers for the FitzHugh-Nagumo RK4 core.
package fnr_pkg;

    localparam int unsigned QW        = 32;
    localparam int unsigned ACCW      = 35;
    localparam int unsigned REMW      = 64;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DRV_STAGES = 6;
    localparam int unsigned FIN_STAGES = 7;

    localparam logic [CFG_IDX_W-1:0] REG_A      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VSCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOFF   = 3'd7;

    localparam logic [1:0] ADV_NONE = 2'd0;
    localparam logic [1:0] ADV_HALF = 2'd1;
    localparam logic [1:0] ADV_FULL = 2'd2;

    localparam logic signed [31:0] ONE_Q   = 32'sd65536;
    localparam logic signed [31:0] Q_MAX   = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN   = 32'sh80000000;
    localparam logic signed [65:0] SAT_HI  = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO  = -66'sd2147483648;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] alpha;
        logic        [30:0] dt;
        logic signed [31:0] gain;
        logic        [30:0] vscale;
        logic signed [31:0] voff;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{a: 32'sd0, b: 32'sd0, c: 32'sd65536, alpha: 32'sd0,
                                   dt: 31'd65536, gain: 32'sd65536, vscale: 31'd65536,
                                   voff: 32'sd0};

    // One cell on its way through the integrator.
    typedef struct packed {
        logic signed [31:0]     x0;
        logic signed [31:0]     x1;
        logic signed [31:0]     fext;
        logic signed [31:0]     f0;
        logic signed [31:0]     f1;
        logic signed [ACCW-1:0] acc0;
        logic signed [ACCW-1:0] acc1;
    } t_tok;

    typedef struct packed {
        t_tok tok;
        logic neg;
        logic zero;
        logic ovf;
    } t_dside;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > SAT_HI) begin
            return Q_MAX;
        end else if (v < SAT_LO) begin
            return Q_MIN;
        end
        return $signed(v[31:0]);
    endfunction

    function automatic logic signed [31:0] mulq16(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return sat32(66'((p + 64'sd32768) >>> 16));
    endfunction

    function automatic logic signed [31:0] mulq17(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return sat32(66'((p + 64'sd65536) >>> 17));
    endfunction

    // One base-16 digit of a division by three: returns {quotient digit, remainder}.
    function automatic logic [5:0] div3_nib(input logic [1:0] rem, input logic [3:0] nib);
        logic [5:0]  v;
        logic [11:0] p;
        logic [3:0]  q;
        logic [5:0]  r;
        v = {rem, nib};
        p = 12'(v) * 12'd43;
        q = p[10:7];
        r = v - 6'(q) * 6'd3;
        return {q, r[1:0]};
    endfunction

endpackage

/* rtl/core/fnr_if.sv */
// Channel interfaces of the FitzHugh-Nagumo RK4 core.
interface fnr_in_if;
    import fnr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] voltage_in;
    logic signed [QW-1:0] recovery_in;
    logic signed [QW-1:0] stimulus;
    modport source (output valid, voltage_in, recovery_in, stimulus, input ready);
    modport sink   (input valid, voltage_in, recovery_in, stimulus, output ready);
endinterface

interface fnr_out_if;
    import fnr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] voltage_out;
    logic signed [QW-1:0] recovery_out;
    modport source (output valid, voltage_out, recovery_out, input ready);
    modport sink   (input valid, voltage_out, recovery_out, output ready);
endinterface

interface fnr_cfg_if;
    import fnr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [QW-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/fnr_div.sv */
// Pipelined restoring divider that normalizes the voltage, one quotient bit per stage.
module fnr_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [63:0]            i_rem,
    input  logic [31:0]            i_den,
    input  fnr_pkg::t_dside        i_side,
    output logic                   o_vld,
    output logic [31:0]            o_quo,
    output fnr_pkg::t_dside        o_side
);
    import fnr_pkg::*;

    logic [QW-1:0]   r_vld;
    logic [REMW-1:0] r_rem  [QW];
    logic [QW-1:0]   r_quo  [QW];
    t_dside          r_side [QW];
    logic [REMW-1:0] n_rem  [QW];
    logic [QW-1:0]   n_quo  [QW];
    logic [REMW-1:0] w_rem_in [QW];
    logic [QW-1:0]   w_quo_in [QW];

    always_comb begin
        logic [REMW-1:0] v_sub;
        w_rem_in[0] = i_rem;
        w_quo_in[0] = '0;
        for (int k = 1; k < QW; k++) begin
            w_rem_in[k] = r_rem[k-1];
            w_quo_in[k] = r_quo[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            v_sub    = 64'(i_den) << (QW - 1 - k);
            n_rem[k] = w_rem_in[k];
            n_quo[k] = w_quo_in[k];
            if (w_rem_in[k] >= v_sub) begin
                n_rem[k] = w_rem_in[k] - v_sub;
                n_quo[k][QW-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
            for (int k = 1; k < QW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule

/* rtl/core/fnr_deriv.sv */
// One RK4 stage: optional advance of the state, then the derivative and its weighted sum.
module fnr_deriv (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fnr_pkg::t_cfg i_cfg,
    input  logic [1:0]    i_mode,
    input  logic          i_dbl,
    input  logic          i_vld,
    input  fnr_pkg::t_tok i_tok,
    output logic          o_vld,
    output fnr_pkg::t_tok o_tok
);
    import fnr_pkg::*;

    typedef struct packed {
        t_tok               tok;
        logic signed [31:0] xs0;
        logic signed [31:0] xs1;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        logic signed [31:0] rb;
        logic signed [31:0] m1;
        logic signed [31:0] fr1;
        logic signed [31:0] cub;
        logic signed [31:0] inner;
    } t_dst;

    logic [DRV_STAGES-1:0] r_vld;
    t_dst                  r_st [DRV_STAGES];
    t_dst                  n_st [DRV_STAGES];
    logic signed [31:0]    w_dt;

    assign w_dt = $signed({1'b0, i_cfg.dt});

    always_comb begin
        logic signed [31:0] v_f0;
        // Advance the base state along the previous slope.
        n_st[0]     = '0;
        n_st[0].tok = i_tok;
        case (i_mode)
            ADV_HALF: begin
                n_st[0].xs0 = sat32(66'(i_tok.x0) + 66'(mulq17(w_dt, i_tok.f0)));
                n_st[0].xs1 = sat32(66'(i_tok.x1) + 66'(mulq17(w_dt, i_tok.f1)));
            end
            ADV_FULL: begin
                n_st[0].xs0 = sat32(66'(i_tok.x0) + 66'(mulq16(w_dt, i_tok.f0)));
                n_st[0].xs1 = sat32(66'(i_tok.x1) + 66'(mulq16(w_dt, i_tok.f1)));
            end
            default: begin
                n_st[0].xs0 = i_tok.x0;
                n_st[0].xs1 = i_tok.x1;
            end
        endcase

        n_st[1]    = r_st[0];
        n_st[1].t1 = sat32(66'(r_st[0].xs0) - 66'(i_cfg.alpha));
        n_st[1].t2 = sat32(66'(ONE_Q) - 66'(r_st[0].xs0));
        n_st[1].rb = mulq16(i_cfg.b, r_st[0].xs1);

        n_st[2]     = r_st[1];
        n_st[2].m1  = mulq16(r_st[1].xs0, r_st[1].t1);
        n_st[2].fr1 = sat32(66'(sat32(66'(r_st[1].xs0) - 66'(r_st[1].rb))) + 66'(i_cfg.a));

        n_st[3]     = r_st[2];
        n_st[3].cub = mulq16(r_st[2].m1, r_st[2].t2);

        n_st[4]       = r_st[3];
        n_st[4].inner = sat32(66'(r_st[3].cub) - 66'(r_st[3].xs1));

        v_f0 = sat32(66'(mulq16(i_cfg.c, r_st[4].inner)) + 66'(r_st[4].tok.fext));
        n_st[5]          = r_st[4];
        n_st[5].tok.f0   = v_f0;
        n_st[5].tok.f1   = r_st[4].fr1;
        n_st[5].tok.acc0 = r_st[4].tok.acc0 + (ACCW'(v_f0) <<< i_dbl);
        n_st[5].tok.acc1 = r_st[4].tok.acc1 + (ACCW'(r_st[4].fr1) <<< i_dbl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DRV_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DRV_STAGES; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_vld = r_vld[DRV_STAGES-1];
    assign o_tok = r_st[DRV_STAGES-1].tok;

endmodule

/* rtl/core/fnr_fin.sv */
// Final RK4 combination, state update and scaling of the voltage back to physical units.
module fnr_fin (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  fnr_pkg::t_cfg      i_cfg,
    input  logic               i_vld,
    input  fnr_pkg::t_tok      i_tok,
    output logic               o_vld,
    output logic signed [31:0] o_vout,
    output logic signed [31:0] o_rout
);
    import fnr_pkg::*;

    typedef struct packed {
        t_tok               tok;
        logic [35:0]        up0;
        logic [35:0]        up1;
        logic [35:0]        q0;
        logic [35:0]        q1;
        logic [1:0]         rem0;
        logic [1:0]         rem1;
        logic signed [31:0] inc0;
        logic signed [31:0] inc1;
        logic signed [31:0] x0n;
        logic signed [31:0] x1n;
        logic signed [31:0] vout;
    } t_fst;

    // Offset that makes the halved sum nonnegative before the divide by three.
    localparam logic signed [35:0] DIV_OFS = 36'sd25769803776;
    localparam logic [35:0]        Q_OFS   = 36'h200000000;

    logic [FIN_STAGES-1:0] r_vld;
    t_fst                  r_st [FIN_STAGES];
    t_fst                  n_st [FIN_STAGES];
    logic signed [31:0]    w_dt;
    logic signed [31:0]    w_vs;

    assign w_dt = $signed({1'b0, i_cfg.dt});
    assign w_vs = $signed({1'b0, i_cfg.vscale});

    always_comb begin
        logic signed [35:0] v_u0;
        logic signed [35:0] v_u1;
        logic [5:0]         v_d;
        logic [35:0]        v_w0;
        logic [35:0]        v_w1;
        int                 v_idx;
        // floor((S + 3) / 6) is taken as floor(floor((S + 3) / 2) / 3).
        v_u0 = (36'(i_tok.acc0) + 36'sd3) >>> 1;
        v_u1 = (36'(i_tok.acc1) + 36'sd3) >>> 1;
        n_st[0]     = '0;
        n_st[0].tok = i_tok;
        n_st[0].up0 = $unsigned(v_u0 + DIV_OFS);
        n_st[0].up1 = $unsigned(v_u1 + DIV_OFS);

        for (int s = 1; s <= 3; s++) begin
            n_st[s] = r_st[s-1];
            for (int j = 0; j < 3; j++) begin
                v_idx = 8 - 3 * (s - 1) - j;
                v_d = div3_nib(n_st[s].rem0, n_st[s].up0[4*v_idx +: 4]);
                n_st[s].q0[4*v_idx +: 4] = v_d[5:2];
                n_st[s].rem0             = v_d[1:0];
                v_d = div3_nib(n_st[s].rem1, n_st[s].up1[4*v_idx +: 4]);
                n_st[s].q1[4*v_idx +: 4] = v_d[5:2];
                n_st[s].rem1             = v_d[1:0];
            end
        end

        v_w0 = r_st[3].q0 - Q_OFS;
        v_w1 = r_st[3].q1 - Q_OFS;
        n_st[4]      = r_st[3];
        n_st[4].inc0 = mulq16(w_dt, $signed(v_w0[31:0]));
        n_st[4].inc1 = mulq16(w_dt, $signed(v_w1[31:0]));

        n_st[5]     = r_st[4];
        n_st[5].x0n = sat32(66'(r_st[4].tok.x0) + 66'(r_st[4].inc0));
        n_st[5].x1n = sat32(66'(r_st[4].tok.x1) + 66'(r_st[4].inc1));

        n_st[6]      = r_st[5];
        n_st[6].vout = sat32(66'(mulq16(r_st[5].x0n, w_vs)) + 66'(i_cfg.voff));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[FIN_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < FIN_STAGES; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_vld  = r_vld[FIN_STAGES-1];
    assign o_vout = r_st[FIN_STAGES-1].vout;
    assign o_rout = r_st[FIN_STAGES-1].x1n;

endmodule

/* rtl/core/fitzhugh_nagumo_rk4_step_core.sv */
// Top level of the FitzHugh-Nagumo RK4 step core.
//
//   Channel  Role    Carries
//   i_in     sink    voltage_in, recovery_in, stimulus (signed Q16.16)
//   o_out    source  voltage_out, recovery_out (signed Q16.16)
//   i_cfg    sink    register index and write data, always ready
//
// One cell enters per cycle while no result is stalled at o_out.
// Between input and output lie the 32-stage voltage divider, four 6-stage derivative units and the final unit.
// Synchronous reset clears the valid bits and loads the register defaults.
// When a result waits at o_out, the whole pipeline holds and i_in.ready drops.
module fitzhugh_nagumo_rk4_step_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fnr_in_if.sink    i_in,
    fnr_out_if.source o_out,
    fnr_cfg_if.sink   i_cfg
);
    import fnr_pkg::*;

    t_cfg               r_cfg;
    logic               w_en;

    logic               r_s1_vld;
    logic signed [32:0] r_s1_d;
    t_tok               r_s1_tok;

    logic               r_s2_vld;
    logic [REMW-1:0]    r_s2_rem;
    t_dside             r_s2_side;

    logic               w_div_vld;
    logic [QW-1:0]      w_div_quo;
    t_dside             w_div_side;

    logic               r_s3_vld;
    t_tok               r_s3_tok;

    logic               w_d1_vld, w_d2_vld, w_d3_vld, w_d4_vld;
    t_tok               w_d1_tok, w_d2_tok, w_d3_tok, w_d4_tok;

    logic               w_fin_vld;
    logic signed [31:0] w_vout;
    logic signed [31:0] w_rout;

    logic signed [50:0] w_num;
    logic [31:0]        w_den;
    logic               w_neg;
    logic [REMW-1:0]    w_mag;
    t_dside             n_s2_side;
    t_tok               n_s1_tok;
    t_tok               n_s3_tok;

    // Configuration must be written only while the pipeline is empty; the block itself does not enforce this.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_A:      r_cfg.a      <= $signed(i_cfg.data);
                REG_B:      r_cfg.b      <= $signed(i_cfg.data);
                REG_C:      r_cfg.c      <= $signed(i_cfg.data);
                REG_ALPHA:  r_cfg.alpha  <= $signed(i_cfg.data);
                REG_DT:     r_cfg.dt     <= i_cfg.data[30:0];
                REG_GAIN:   r_cfg.gain   <= $signed(i_cfg.data);
                REG_VSCALE: r_cfg.vscale <= i_cfg.data[30:0];
                REG_VOFF:   r_cfg.voff   <= $signed(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    assign w_en       = !w_fin_vld || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        n_s1_tok      = '0;
        n_s1_tok.x1   = i_in.recovery_in;
        n_s1_tok.fext = mulq16(r_cfg.gain, i_in.stimulus);
    end

    // Floor division by 2*vscale is done on a magnitude; a negative numerator
    // is rounded up in magnitude by adding the divisor less one.
    assign w_num = (51'(r_s1_d) <<< 17) + 51'($signed({1'b0, r_cfg.vscale}));
    assign w_den = {r_cfg.vscale, 1'b0};
    assign w_neg = w_num[50];
    assign w_mag = w_neg ? 64'($unsigned(-w_num)) + 64'(w_den) - 64'd1
                         : 64'($unsigned(w_num));

    always_comb begin
        n_s2_side      = '0;
        n_s2_side.tok  = r_s1_tok;
        n_s2_side.neg  = w_neg;
        n_s2_side.zero = (r_s1_d == '0);
        n_s2_side.ovf  = (w_mag >= {w_den, 32'd0});
    end

    always_comb begin
        n_s3_tok = w_div_side.tok;
        if (r_cfg.vscale == '0) begin
            n_s3_tok.x0 = w_div_side.zero ? 32'sd0 : (w_div_side.neg ? Q_MIN : Q_MAX);
        end else if (w_div_side.ovf) begin
            n_s3_tok.x0 = w_div_side.neg ? Q_MIN : Q_MAX;
        end else if (w_div_side.neg) begin
            n_s3_tok.x0 = (w_div_quo > 32'h80000000) ? Q_MIN
                                                      : $signed(32'(-{1'b0, w_div_quo}));
        end else begin
            n_s3_tok.x0 = w_div_quo[31] ? Q_MAX : $signed(w_div_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_in.valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_d    <= 33'(i_in.voltage_in) - 33'(r_cfg.voff);
            r_s1_tok  <= n_s1_tok;
            r_s2_rem  <= w_mag;
            r_s2_side <= n_s2_side;
            r_s3_tok  <= n_s3_tok;
        end
    end

    fnr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s2_vld),
        .i_rem   (r_s2_rem),
        .i_den   (w_den),
        .i_side  (r_s2_side),
        .o_vld   (w_div_vld),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    fnr_deriv u_k1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_cfg (r_cfg),
        .i_mode (ADV_NONE), .i_dbl (1'b0),
        .i_vld (r_s3_vld), .i_tok (r_s3_tok), .o_vld (w_d1_vld), .o_tok (w_d1_tok)
    );

    fnr_deriv u_k2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_cfg (r_cfg),
        .i_mode (ADV_HALF), .i_dbl (1'b1),
        .i_vld (w_d1_vld), .i_tok (w_d1_tok), .o_vld (w_d2_vld), .o_tok (w_d2_tok)
    );

    fnr_deriv u_k3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_cfg (r_cfg),
        .i_mode (ADV_HALF), .i_dbl (1'b1),
        .i_vld (w_d2_vld), .i_tok (w_d2_tok), .o_vld (w_d3_vld), .o_tok (w_d3_tok)
    );

    fnr_deriv u_k4 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_cfg (r_cfg),
        .i_mode (ADV_FULL), .i_dbl (1'b0),
        .i_vld (w_d3_vld), .i_tok (w_d3_tok), .o_vld (w_d4_vld), .o_tok (w_d4_tok)
    );

    fnr_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_vld   (w_d4_vld),
        .i_tok   (w_d4_tok),
        .o_vld   (w_fin_vld),
        .o_vout  (w_vout),
        .o_rout  (w_rout)
    );

    assign o_out.valid        = w_fin_vld;
    assign o_out.voltage_out  = w_vout;
    assign o_out.recovery_out = w_rout;

`ifndef SYNTHESIS
    a_rst_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while the result is stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_s1_vld)
        else $error("accepted transaction missing from the first stage");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_div_vld))
        else $error("divider moved during a stall");
`endif

endmodule
